### src/bcdclk_pkg.sv
// Shared types and constants for the BCD clock with multiplexed digit scan.
// Holds the segment table, the digit enable table and the display struct.
// No dependencies.
package bcdclk_pkg;

    localparam int unsigned SEC_W     = 6;
    localparam int unsigned SEC_LAST  = 59;
    localparam int unsigned DIG_LAST  = 9;
    localparam int unsigned MT_LAST   = 5;
    localparam int unsigned HT_LAST   = 3;
    localparam int unsigned DIV_W     = 8;
    localparam logic [DIV_W-1:0] DIV_RESET = 8'd12;

    localparam logic [1:0] IDX_HOUR_TENS = 2'd0;
    localparam logic [1:0] IDX_HOUR_ONES = 2'd1;
    localparam logic [1:0] IDX_MIN_TENS  = 2'd2;
    localparam logic [1:0] IDX_MIN_ONES  = 2'd3;

    typedef struct packed {
        logic [5:0] enable;
        logic [5:0] seg_low;
        logic [2:0] seg_high;
    } t_disp;

    typedef struct packed {
        logic [5:0] low;
        logic [2:0] high;
    } t_seg;

    function automatic t_seg seg_pattern(input logic [3:0] digit);
        t_seg s;
        case (digit)
            4'd0: s = '{low: 6'd63, high: 3'd0};
            4'd1: s = '{low: 6'd6,  high: 3'd0};
            4'd2: s = '{low: 6'd27, high: 3'd4};
            4'd3: s = '{low: 6'd15, high: 3'd4};
            4'd4: s = '{low: 6'd44, high: 3'd4};
            4'd5: s = '{low: 6'd45, high: 3'd4};
            4'd6: s = '{low: 6'd61, high: 3'd4};
            4'd7: s = '{low: 6'd7,  high: 3'd0};
            4'd8: s = '{low: 6'd63, high: 3'd4};
            4'd9: s = '{low: 6'd47, high: 3'd4};
            default: s = '{low: 6'd0, high: 3'd0};
        endcase
        return s;
    endfunction

    function automatic logic [5:0] digit_enable(input logic [1:0] idx);
        logic [5:0] e;
        case (idx)
            IDX_HOUR_TENS: e = 6'd32;
            IDX_HOUR_ONES: e = 6'd16;
            IDX_MIN_TENS:  e = 6'd8;
            IDX_MIN_ONES:  e = 6'd4;
            default:       e = 6'd0;
        endcase
        return e;
    endfunction

endpackage

### src/bcd_clock_with_led_digit_scan.sv
// Top level: 24-hour BCD clock built as a chain of counter cells plus a
// multiplexed digit scan, with a registered result stage.
// Depends on bcdclk_pkg, bcdclk_digit_cell and bcdclk_scan.
//
//   channel | valid    | stall    | payload
//   --------+----------+----------+------------------------------------------
//   input   | i_valid  | o_stall  | i_second_tick
//   output  | o_valid  | i_stall  | o_digit_enable, o_segment_low/high, digits
//   config  | i_cfg_wr_en (no stall) | i_cfg_wr_data (scan_divide)
//
// One item per clock while o_stall is low; each item's result is registered and shows in the cycle after acceptance.
// The seconds-to-hours carry ripples through the cell chain in the accepting cycle.
// Input stalls only while a result is held and the output side stalls.
// Synchronous reset clears the clock to 00:00:00 and scan_divide to 12.
module bcd_clock_with_led_digit_scan
    import bcdclk_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic             i_second_tick,
    input  logic             i_cfg_wr_en,
    input  logic [DIV_W-1:0] i_cfg_wr_data,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [5:0]       o_digit_enable,
    output logic [5:0]       o_segment_low,
    output logic [2:0]       o_segment_high,
    output logic [1:0]       o_hour_tens,
    output logic [3:0]       o_hour_ones,
    output logic [2:0]       o_minute_tens,
    output logic [3:0]       o_minute_ones
);

    logic accept;

    logic [SEC_W-1:0] sec_val, sec_next;
    logic [3:0]       mo_val, mo_next;
    logic [2:0]       mt_val, mt_next;
    logic [3:0]       ho_val, ho_next;
    logic [1:0]       ht_val, ht_next;
    logic             sec_carry, mo_carry, mt_carry, ho_carry, ht_carry;
    logic             hour_clr;
    t_disp            disp;

    logic             r_valid;
    t_disp            r_disp;
    logic [1:0]       r_hour_tens;
    logic [3:0]       r_hour_ones;
    logic [2:0]       r_minute_tens;
    logic [3:0]       r_minute_ones;

    assign o_stall = r_valid && i_stall;
    assign accept  = i_valid && !o_stall;

    // wrap 23 -> 00 when the hour advances
    assign hour_clr = mt_carry && (ht_val >= 2'd2) && (ho_val >= 4'd3) &&
                      (ho_val != 4'(DIG_LAST));

    bcdclk_digit_cell #(.WIDTH(SEC_W), .LAST(SEC_LAST)) u_sec (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(accept),
        .i_inc(i_second_tick), .i_clr(1'b0),
        .o_val(sec_val), .o_next(sec_next), .o_carry(sec_carry)
    );

    bcdclk_digit_cell #(.WIDTH(4), .LAST(DIG_LAST)) u_min_ones (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(accept),
        .i_inc(sec_carry), .i_clr(1'b0),
        .o_val(mo_val), .o_next(mo_next), .o_carry(mo_carry)
    );

    bcdclk_digit_cell #(.WIDTH(3), .LAST(MT_LAST)) u_min_tens (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(accept),
        .i_inc(mo_carry), .i_clr(1'b0),
        .o_val(mt_val), .o_next(mt_next), .o_carry(mt_carry)
    );

    bcdclk_digit_cell #(.WIDTH(4), .LAST(DIG_LAST)) u_hour_ones (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(accept),
        .i_inc(mt_carry), .i_clr(hour_clr),
        .o_val(ho_val), .o_next(ho_next), .o_carry(ho_carry)
    );

    bcdclk_digit_cell #(.WIDTH(2), .LAST(HT_LAST)) u_hour_tens (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(accept),
        .i_inc(ho_carry), .i_clr(hour_clr),
        .o_val(ht_val), .o_next(ht_next), .o_carry(ht_carry)
    );

    bcdclk_scan u_scan (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (accept),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_hour_tens   (ht_next),
        .i_hour_ones   (ho_next),
        .i_minute_tens (mt_next),
        .i_minute_ones (mo_next),
        .o_disp        (disp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_disp        <= disp;
            r_hour_tens   <= ht_next;
            r_hour_ones   <= ho_next;
            r_minute_tens <= mt_next;
            r_minute_ones <= mo_next;
        end
    end

    assign o_valid        = r_valid;
    assign o_digit_enable = r_disp.enable;
    assign o_segment_low  = r_disp.seg_low;
    assign o_segment_high = r_disp.seg_high;
    assign o_hour_tens    = r_hour_tens;
    assign o_hour_ones    = r_hour_ones;
    assign o_minute_tens  = r_minute_tens;
    assign o_minute_ones  = r_minute_ones;

    // seconds value and next value, minute-tens value and top carry are not used elsewhere
    logic unused_ok;
    assign unused_ok = ^{sec_val, mt_val, ht_carry, sec_next};

endmodule

### src/bcdclk_digit_cell.sv
// One counter cell of the clock chain: counts 0..LAST, passes a carry on.
// A clear input forces the cell to zero for the 24-hour wrap.
// Uses no package.
module bcdclk_digit_cell #(
    parameter int unsigned WIDTH = 4,
    parameter int unsigned LAST  = 9
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_inc,
    input  logic             i_clr,
    output logic [WIDTH-1:0] o_val,
    output logic [WIDTH-1:0] o_next,
    output logic             o_carry
);

    logic [WIDTH-1:0] r_val;
    logic [WIDTH-1:0] n_val;

    assign o_carry = i_inc && (r_val == WIDTH'(LAST));

    always_comb begin
        n_val = r_val;
        if (i_clr) begin
            n_val = '0;
        end else if (o_carry) begin
            n_val = '0;
        end else if (i_inc) begin
            n_val = r_val + WIDTH'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_val <= '0;
        end else if (i_en) begin
            r_val <= n_val;
        end
    end

    assign o_val  = r_val;
    assign o_next = n_val;

endmodule

### src/bcdclk_scan.sv
// Scan divider and digit index; selects and decodes the shown digit.
// Holds the scan_divide register. Depends on bcdclk_pkg.
module bcdclk_scan
    import bcdclk_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_cfg_wr_en,
    input  logic [DIV_W-1:0] i_cfg_wr_data,
    input  logic [1:0]       i_hour_tens,
    input  logic [3:0]       i_hour_ones,
    input  logic [2:0]       i_minute_tens,
    input  logic [3:0]       i_minute_ones,
    output t_disp            o_disp
);

    logic [DIV_W-1:0] r_divide;
    logic [DIV_W-1:0] r_count;
    logic [DIV_W-1:0] n_count;
    logic [1:0]       r_index;
    logic [1:0]       n_index;
    logic [DIV_W:0]   count_inc;
    logic [3:0]       shown;
    t_seg             seg;

    always_comb begin
        count_inc = {1'b0, r_count} + (DIV_W + 1)'(1);
        if (count_inc >= {1'b0, r_divide}) begin
            n_count = '0;
            n_index = r_index + 2'd1;
        end else begin
            n_count = count_inc[DIV_W-1:0];
            n_index = r_index;
        end
    end

    always_comb begin
        case (n_index)
            IDX_HOUR_TENS: shown = {2'b00, i_hour_tens};
            IDX_HOUR_ONES: shown = i_hour_ones;
            IDX_MIN_TENS:  shown = {1'b0, i_minute_tens};
            IDX_MIN_ONES:  shown = i_minute_ones;
            default:       shown = i_minute_ones;
        endcase
        seg = seg_pattern(shown);
        o_disp.enable   = digit_enable(n_index);
        o_disp.seg_low  = seg.low;
        o_disp.seg_high = seg.high;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_divide <= DIV_RESET;
        end else if (i_cfg_wr_en) begin
            r_divide <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_index <= IDX_HOUR_TENS;
        end else if (i_en) begin
            r_count <= n_count;
            r_index <= n_index;
        end
    end

endmodule

### src/bcdclk_checker.sv
// Port-level checks for the BCD clock top level, attached with a bind.
// Depends on bcd_clock_with_led_digit_scan port names only.
module bcdclk_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_stall,
    input logic [5:0] o_digit_enable,
    input logic [5:0] o_segment_low,
    input logic [2:0] o_segment_high,
    input logic [1:0] o_hour_tens,
    input logic [3:0] o_hour_ones,
    input logic [2:0] o_minute_tens,
    input logic [3:0] o_minute_ones
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_digit_enable) &&
        $stable(o_segment_low) && $stable(o_minute_ones))
        else $error("stalled item changed");

    a_enable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $onehot(o_digit_enable) && (o_digit_enable[1:0] == 2'b00))
        else $error("digit enable not a single digit slot");

    a_seg_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_segment_high == 3'd0) || (o_segment_high == 3'd4))
        else $error("bad upper segment value");

    a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_hour_tens < 2'd2) && (o_hour_ones <= 4'd9)) ||
        ((o_hour_tens == 2'd2) && (o_hour_ones < 4'd4)))
        else $error("hour out of range");

    a_minute: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_minute_tens <= 3'd5) && (o_minute_ones <= 4'd9) &&
        (o_segment_low != 6'd0))
        else $error("minute out of range or blank digit");

endmodule

bind bcd_clock_with_led_digit_scan bcdclk_checker u_bcdclk_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_digit_enable (o_digit_enable),
    .o_segment_low  (o_segment_low),
    .o_segment_high (o_segment_high),
    .o_hour_tens    (o_hour_tens),
    .o_hour_ones    (o_hour_ones),
    .o_minute_tens  (o_minute_tens),
    .o_minute_ones  (o_minute_ones)
);
